### rtl/cpu_exu_pkg.sv
// shared types, constants and helpers of the cpu16 execute unit
`default_nettype none

package cpu_exu_pkg;

   localparam int NUM_REGS    = 32;
   localparam int DATA_WIDTH  = 16;
   localparam int OP_W        = 5;
   localparam int REG_FIELD_W = 5;
   localparam int IMM_W       = 16;
   localparam int REG_IDX_W   = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

   localparam logic [DATA_WIDTH-1:0] TOP_BIT = {1'b1, {(DATA_WIDTH-1){1'b0}}};
   localparam logic [DATA_WIDTH-1:0] LOW_BIT = {{(DATA_WIDTH-1){1'b0}}, 1'b1};

   typedef enum logic [OP_W-1:0] {
      OP_NOP   = 5'd0,
      OP_SLEEP = 5'd1,
      OP_LOADI = 5'd2,
      OP_STORE = 5'd3,
      OP_MOVE  = 5'd4,
      OP_JUMP  = 5'd5,
      OP_JUMPC = 5'd6,
      OP_JUMPZ = 5'd7,
      OP_AND   = 5'd8,
      OP_OR    = 5'd9,
      OP_XOR   = 5'd10,
      OP_NOT   = 5'd11,
      OP_ADD   = 5'd12,
      OP_ADDC  = 5'd13,
      OP_SUB   = 5'd14,
      OP_SUBC  = 5'd15,
      OP_COMP  = 5'd16,
      OP_INC   = 5'd17,
      OP_DEC   = 5'd18,
      OP_SHL   = 5'd19,
      OP_SHR   = 5'd20,
      OP_SHLC  = 5'd21,
      OP_SHRC  = 5'd22
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_HALT    = 2'd1,
      STATUS_INVALID = 2'd2
   } status_type;

   typedef struct packed {
      logic                  wr_en;
      logic [DATA_WIDTH-1:0] wr_data;
      logic                  flags_en;
      logic                  carry;
      logic                  zero;
      status_type            status;
      logic                  jump;
      logic                  store;
   } alu_out_type;

   function automatic logic reg_in_range(input logic [REG_FIELD_W-1:0] idx);
      return int'(idx) < NUM_REGS;
   endfunction

endpackage

`default_nettype wire

### rtl/cpu_exu_regfile.sv
// register file: two registered read ports, one write port, valid bits, write forwarding
`default_nettype none

module cpu_exu_regfile
   import cpu_exu_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   rd_en,
   input  wire logic [REG_FIELD_W-1:0] rd_addr_a,
   input  wire logic [REG_FIELD_W-1:0] rd_addr_b,
   input  wire logic                   wr_en,
   input  wire logic [REG_FIELD_W-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0]  wr_data,
   output logic      [DATA_WIDTH-1:0]  rd_data_a,
   output logic      [DATA_WIDTH-1:0]  rd_data_b
);

   logic [DATA_WIDTH-1:0]  mem_ff [NUM_REGS];
   logic [NUM_REGS-1:0]    valid_ff;
   logic [DATA_WIDTH-1:0]  rd_raw_a_ff;
   logic [DATA_WIDTH-1:0]  rd_raw_b_ff;
   logic                   rd_ok_a_ff;
   logic                   rd_ok_b_ff;
   logic [REG_FIELD_W-1:0] rd_addr_a_ff;
   logic [REG_FIELD_W-1:0] rd_addr_b_ff;
   logic                   fwd_vld_ff;
   logic [REG_FIELD_W-1:0] fwd_addr_ff;
   logic [DATA_WIDTH-1:0]  fwd_data_ff;
   logic                   wr_ok;

   assign wr_ok = wr_en && reg_in_range(wr_addr);

   always_ff @(posedge clock) begin
      if (wr_ok) begin
         mem_ff[wr_addr[REG_IDX_W-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_raw_a_ff  <= mem_ff[rd_addr_a[REG_IDX_W-1:0]];
         rd_raw_b_ff  <= mem_ff[rd_addr_b[REG_IDX_W-1:0]];
         rd_ok_a_ff   <= reg_in_range(rd_addr_a) && valid_ff[rd_addr_a[REG_IDX_W-1:0]];
         rd_ok_b_ff   <= reg_in_range(rd_addr_b) && valid_ff[rd_addr_b[REG_IDX_W-1:0]];
         rd_addr_a_ff <= rd_addr_a;
         rd_addr_b_ff <= rd_addr_b;
      end
      if (wr_ok) begin
         fwd_addr_ff <= wr_addr;
         fwd_data_ff <= wr_data;
      end
   end

   // entries never written read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         fwd_vld_ff <= 1'b0;
      end else if (wr_ok) begin
         valid_ff[wr_addr[REG_IDX_W-1:0]] <= 1'b1;
         fwd_vld_ff                       <= 1'b1;
      end
   end

   // the latest write always wins over the registered array data
   always_comb begin
      if (fwd_vld_ff && (fwd_addr_ff == rd_addr_a_ff)) begin
         rd_data_a = fwd_data_ff;
      end else begin
         rd_data_a = rd_ok_a_ff ? rd_raw_a_ff : '0;
      end
      if (fwd_vld_ff && (fwd_addr_ff == rd_addr_b_ff)) begin
         rd_data_b = fwd_data_ff;
      end else begin
         rd_data_b = rd_ok_b_ff ? rd_raw_b_ff : '0;
      end
   end

endmodule

`default_nettype wire

### rtl/cpu_exu_alu.sv
// alu and flag logic for one instruction
`default_nettype none

module cpu_exu_alu
   import cpu_exu_pkg::*;
(
   input  wire logic [OP_W-1:0]       op,
   input  wire logic [DATA_WIDTH-1:0] a,
   input  wire logic [DATA_WIDTH-1:0] b,
   input  wire logic [IMM_W-1:0]      imm,
   input  wire logic                  carry_in,
   input  wire logic                  zero_in,
   output alu_out_type                res
);

   logic                  sub_sel;
   logic [DATA_WIDTH-1:0] addend;
   logic                  cin;
   logic [DATA_WIDTH:0]   sum;
   logic                  arith;

   // shared adder: carry is bit 16, borrow for subtraction
   always_comb begin
      sub_sel = 1'b0;
      addend  = b;
      cin     = 1'b0;
      arith   = 1'b0;
      unique case (op_type'(op))
         OP_ADD:  begin arith = 1'b1; end
         OP_ADDC: begin arith = 1'b1; cin = carry_in; end
         OP_SUB:  begin arith = 1'b1; sub_sel = 1'b1; end
         OP_SUBC: begin arith = 1'b1; sub_sel = 1'b1; cin = carry_in; end
         OP_COMP: begin arith = 1'b1; sub_sel = 1'b1; end
         OP_INC:  begin arith = 1'b1; addend = LOW_BIT; end
         OP_DEC:  begin arith = 1'b1; sub_sel = 1'b1; addend = LOW_BIT; end
         default: begin arith = 1'b0; end
      endcase
      if (sub_sel) begin
         sum = {1'b0, a} - {1'b0, addend} - {{DATA_WIDTH{1'b0}}, cin};
      end else begin
         sum = {1'b0, a} + {1'b0, addend} + {{DATA_WIDTH{1'b0}}, cin};
      end
   end

   always_comb begin
      res          = '0;
      res.status   = STATUS_OK;
      res.carry    = carry_in;
      res.zero     = zero_in;
      unique case (op_type'(op))
         OP_NOP:   begin end
         OP_SLEEP: res.status = STATUS_HALT;
         OP_LOADI: begin res.wr_en = 1'b1; res.wr_data = imm; end
         OP_STORE: res.store = 1'b1;
         OP_MOVE:  begin res.wr_en = 1'b1; res.wr_data = b; end
         OP_JUMP:  res.jump = 1'b1;
         OP_JUMPC: res.jump = carry_in;
         OP_JUMPZ: res.jump = zero_in;
         OP_AND, OP_OR, OP_XOR, OP_NOT: begin
            res.wr_en    = 1'b1;
            res.flags_en = 1'b1;
            res.carry    = 1'b0;
            unique case (op_type'(op))
               OP_AND:  res.wr_data = a & b;
               OP_OR:   res.wr_data = a | b;
               OP_XOR:  res.wr_data = a ^ b;
               default: res.wr_data = ~a;
            endcase
            res.zero = (res.wr_data == '0);
         end
         OP_ADD, OP_ADDC, OP_SUB, OP_SUBC, OP_COMP, OP_INC, OP_DEC: begin
            res.wr_en    = arith && (op_type'(op) != OP_COMP);
            res.wr_data  = sum[DATA_WIDTH-1:0];
            res.flags_en = 1'b1;
            res.carry    = sum[DATA_WIDTH];
            res.zero     = (sum[DATA_WIDTH-1:0] == '0);
         end
         OP_SHL, OP_SHLC: begin
            res.wr_en    = 1'b1;
            res.wr_data  = {a[DATA_WIDTH-2:0], (op_type'(op) == OP_SHLC) && carry_in};
            res.flags_en = 1'b1;
            res.carry    = a[DATA_WIDTH-1];
            res.zero     = (res.wr_data == '0);
         end
         OP_SHR, OP_SHRC: begin
            res.wr_en    = 1'b1;
            res.wr_data  = {(op_type'(op) == OP_SHRC) && carry_in, a[DATA_WIDTH-1:1]};
            res.flags_en = 1'b1;
            res.carry    = a[0];
            res.zero     = (res.wr_data == '0);
         end
         default:  res.status = STATUS_INVALID;
      endcase
   end

endmodule

`default_nettype wire

### rtl/cpu16_execute_unit.sv
// top level of the cpu16 execute unit: input stage, alu, flags and result register
`default_nettype none

// channel  | dir | tdata (lowest bit up)                                  | tuser
// ---------+-----+--------------------------------------------------------+-----------
// req      | in  | reg_a[4:0] reg_b[9:5] immediate[25:10], zero [31:26]   | req_type
// rsp      | out | reg_value carry_out zero_out jump_taken jump_target    | status
//          |     | store_valid store_addr store_data, zero [71:68]        |
//
// one instruction per clock unless rsp stalls: a transfer on req starts the register
// file read, the next cycle the alu runs on the read data, and the result lands in the
// rsp register when the execute stage moves on; rsp_tvalid rises once the instruction
// has passed the execute stage register and the result register
// reset clears the flags, the register file valid bits and both pipeline valids
// a stalled rsp holds the execute stage; req_tready drops only while both are full
// and rsp_tready is low

module cpu16_execute_unit
   import cpu_exu_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [31:0] req_tdata,   // reg_a, reg_b, immediate
   input  wire logic [4:0]  req_tuser,   // req_type
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [71:0] rsp_tdata,   // reg_value, carry_out, zero_out, jump_taken,
                                         // jump_target, store_valid, store_addr, store_data
   output logic      [1:0]  rsp_tuser    // status
);

   // execute stage
   logic                   ex_vld_ff;
   logic [OP_W-1:0]        ex_op_ff;
   logic [REG_FIELD_W-1:0] ex_ia_ff;
   logic [IMM_W-1:0]       ex_imm_ff;

   // architectural flags
   logic carry_ff;
   logic zero_ff;

   // result register
   logic        rsp_vld_ff;
   logic [71:0] rsp_data_ff;
   logic [1:0]  rsp_user_ff;
   logic [71:0] rsp_data_in;

   logic                  req_xfer;
   logic                  ex_adv;
   logic [DATA_WIDTH-1:0] op_a;
   logic [DATA_WIDTH-1:0] op_b;
   alu_out_type           alu_res;
   logic                  rf_wr_en;
   logic [DATA_WIDTH-1:0] reg_value;

   // execute stage moves on when the result register is free or being drained
   assign ex_adv     = ex_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !ex_vld_ff || ex_adv;
   assign req_xfer   = req_tvalid && req_tready;

   cpu_exu_regfile u_regfile (
      .clock     (clock),
      .reset     (reset),
      .rd_en     (req_xfer),
      .rd_addr_a (req_tdata[4:0]),
      .rd_addr_b (req_tdata[9:5]),
      .wr_en     (rf_wr_en),
      .wr_addr   (ex_ia_ff),
      .wr_data   (alu_res.wr_data),
      .rd_data_a (op_a),
      .rd_data_b (op_b)
   );

   cpu_exu_alu u_alu (
      .op       (ex_op_ff),
      .a        (op_a),
      .b        (op_b),
      .imm      (ex_imm_ff),
      .carry_in (carry_ff),
      .zero_in  (zero_ff),
      .res      (alu_res)
   );

   // register write and flag update happen when the instruction retires
   assign rf_wr_en = ex_adv && alu_res.wr_en;

   // an out-of-range destination reads back as zero, which op_a already is
   assign reg_value = (alu_res.wr_en && reg_in_range(ex_ia_ff)) ? alu_res.wr_data : op_a;

   always_comb begin
      rsp_data_in          = '0;
      rsp_data_in[15:0]    = reg_value;
      rsp_data_in[16]      = alu_res.flags_en ? alu_res.carry : carry_ff;
      rsp_data_in[17]      = alu_res.flags_en ? alu_res.zero : zero_ff;
      rsp_data_in[18]      = alu_res.jump;
      rsp_data_in[34:19]   = alu_res.jump ? op_a : '0;
      rsp_data_in[35]      = alu_res.store;
      rsp_data_in[51:36]   = alu_res.store ? op_b : '0;
      rsp_data_in[67:52]   = alu_res.store ? op_a : '0;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ex_vld_ff  <= 1'b0;
         rsp_vld_ff <= 1'b0;
         carry_ff   <= 1'b0;
         zero_ff    <= 1'b0;
      end else begin
         if (req_xfer) begin
            ex_vld_ff <= 1'b1;
         end else if (ex_adv) begin
            ex_vld_ff <= 1'b0;
         end
         if (ex_adv) begin
            rsp_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_vld_ff <= 1'b0;
         end
         if (ex_adv && alu_res.flags_en) begin
            carry_ff <= alu_res.carry;
            zero_ff  <= alu_res.zero;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         ex_op_ff  <= req_tuser;
         ex_ia_ff  <= req_tdata[4:0];
         ex_imm_ff <= req_tdata[25:10];
      end
      if (ex_adv) begin
         rsp_data_ff <= rsp_data_in;
         rsp_user_ff <= alu_res.status;
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

endmodule

`default_nettype wire

### verif/tb_cpu16_execute_unit.sv
// testbench of the cpu16 execute unit: predicts every instruction result and checks the rsp stream
`default_nettype none

module tb_cpu16_execute_unit;
   import cpu_exu_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // opcodes past the last defined one must come back as invalid
   localparam logic [OP_W-1:0] OP_FIRST_INVALID = 5'd23;
   localparam logic [OP_W-1:0] OP_LAST_INVALID  = 5'd31;

   localparam int RANDOM_INSTRS = 800;
   localparam int CYCLE_LIMIT   = 300000;
   localparam int DRAIN_CYCLES  = 8;

   // one expected rsp transfer
   typedef struct {
      status_type            status;
      logic [DATA_WIDTH-1:0] reg_value;
      logic                  carry;
      logic                  zero;
      logic                  jump;
      logic [DATA_WIDTH-1:0] jump_target;
      logic                  store;
      logic [DATA_WIDTH-1:0] store_addr;
      logic [DATA_WIDTH-1:0] store_data;
   } exec_result_type;

   // shadow machine state plus the queue of results still owed by the block
   class exec_tracker;
      typedef enum {FLAGS_KEEP, FLAGS_LOGIC, FLAGS_ARITH, FLAGS_COMPARE} flag_rule_type;

      logic [DATA_WIDTH-1:0] regs [NUM_REGS];
      logic                  carry_flag;
      logic                  zero_flag;
      exec_result_type       pending_results [$];
      int unsigned           mismatches;

      function new();
         foreach (regs[i]) regs[i] = '0;
         carry_flag = 1'b0;
         zero_flag  = 1'b0;
         mismatches = 0;
      endfunction

      function logic [DATA_WIDTH-1:0] read_reg(logic [REG_FIELD_W-1:0] idx);
         if (int'(idx) < NUM_REGS) return regs[idx];
         return '0;
      endfunction

      function void write_reg(logic [REG_FIELD_W-1:0] idx, logic [DATA_WIDTH-1:0] val);
         if (int'(idx) < NUM_REGS) regs[idx] = val;
      endfunction

      // run one instruction on the shadow state and queue what the block must return
      function void note_instr(logic [OP_W-1:0] op, logic [REG_FIELD_W-1:0] ra,
                               logic [REG_FIELD_W-1:0] rb, logic [IMM_W-1:0] imm);
         exec_result_type       res;
         logic [DATA_WIDTH-1:0] a;
         logic [DATA_WIDTH-1:0] b;
         logic [DATA_WIDTH:0]   wide;
         logic [DATA_WIDTH-1:0] shifted;
         flag_rule_type         rule;
         a    = read_reg(ra);
         b    = read_reg(rb);
         wide = '0;
         rule = FLAGS_KEEP;
         res.status = STATUS_OK;
         res.jump   = 1'b0;
         res.store  = 1'b0;
         case (op)
            OP_NOP: begin
            end
            OP_SLEEP: res.status = STATUS_HALT;
            OP_LOADI: write_reg(ra, imm);
            OP_STORE: res.store = 1'b1;
            OP_MOVE:  write_reg(ra, b);
            OP_JUMP:  res.jump = 1'b1;
            OP_JUMPC: res.jump = carry_flag;
            OP_JUMPZ: res.jump = zero_flag;
            OP_AND: begin
               wide = {1'b0, a & b};
               rule = FLAGS_LOGIC;
            end
            OP_OR: begin
               wide = {1'b0, a | b};
               rule = FLAGS_LOGIC;
            end
            OP_XOR: begin
               wide = {1'b0, a ^ b};
               rule = FLAGS_LOGIC;
            end
            OP_NOT: begin
               wide = {1'b0, ~a};
               rule = FLAGS_LOGIC;
            end
            OP_ADD: begin
               wide = {1'b0, a} + {1'b0, b};
               rule = FLAGS_ARITH;
            end
            OP_ADDC: begin
               wide = {1'b0, a} + {1'b0, b} + {{DATA_WIDTH{1'b0}}, carry_flag};
               rule = FLAGS_ARITH;
            end
            OP_SUB: begin
               wide = {1'b0, a} - {1'b0, b};
               rule = FLAGS_ARITH;
            end
            OP_SUBC: begin
               wide = {1'b0, a} - {1'b0, b} - {{DATA_WIDTH{1'b0}}, carry_flag};
               rule = FLAGS_ARITH;
            end
            OP_COMP: begin
               wide = {1'b0, a} - {1'b0, b};
               rule = FLAGS_COMPARE;
            end
            OP_INC: begin
               wide = {1'b0, a} + {1'b0, LOW_BIT};
               rule = FLAGS_ARITH;
            end
            OP_DEC: begin
               wide = {1'b0, a} - {1'b0, LOW_BIT};
               rule = FLAGS_ARITH;
            end
            OP_SHL, OP_SHLC: begin
               shifted = {a[DATA_WIDTH-2:0], (op == OP_SHLC) ? carry_flag : 1'b0};
               write_reg(ra, shifted);
               zero_flag  = (shifted == '0);
               carry_flag = a[DATA_WIDTH-1];
            end
            OP_SHR, OP_SHRC: begin
               shifted = {(op == OP_SHRC) ? carry_flag : 1'b0, a[DATA_WIDTH-1:1]};
               write_reg(ra, shifted);
               zero_flag  = (shifted == '0);
               carry_flag = a[0];
            end
            default: res.status = STATUS_INVALID;
         endcase

         if (rule != FLAGS_KEEP) begin
            if (rule != FLAGS_COMPARE) write_reg(ra, wide[DATA_WIDTH-1:0]);
            zero_flag  = (wide[DATA_WIDTH-1:0] == '0);
            carry_flag = (rule == FLAGS_LOGIC) ? 1'b0 : wide[DATA_WIDTH];
         end

         res.reg_value   = read_reg(ra);
         res.carry       = carry_flag;
         res.zero        = zero_flag;
         res.jump_target = res.jump ? a : '0;
         res.store_addr  = res.store ? b : '0;
         res.store_data  = res.store ? a : '0;
         pending_results.push_back(res);
      endfunction

      task report(string msg);
         $display("%0t ns error: %s", $time, msg);
         mismatches++;
      endtask

      task compare_field(string name, logic [DATA_WIDTH-1:0] got, logic [DATA_WIDTH-1:0] want);
         if (got !== want)
            report($sformatf("%s got %0h expected %0h", name, got, want));
      endtask

      // compare one rsp transfer against the oldest owed result
      task check_result(logic [71:0] data, logic [1:0] user);
         exec_result_type want;
         if (pending_results.size() == 0) begin
            report("rsp transfer with no instruction outstanding");
         end else begin
            want = pending_results.pop_front();
            compare_field("status",      16'(user),     16'(want.status));
            compare_field("reg_value",   data[15:0],    want.reg_value);
            compare_field("carry_out",   16'(data[16]), 16'(want.carry));
            compare_field("zero_out",    16'(data[17]), 16'(want.zero));
            compare_field("jump_taken",  16'(data[18]), 16'(want.jump));
            compare_field("jump_target", data[34:19],   want.jump_target);
            compare_field("store_valid", 16'(data[35]), 16'(want.store));
            compare_field("store_addr",  data[51:36],   want.store_addr);
            compare_field("store_data",  data[67:52],   want.store_data);
         end
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;   // reg_a, reg_b, immediate
   logic [4:0]  req_tuser = '0;   // req_type
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;        // reg_value, carry_out, zero_out, jump_taken,
                                  // jump_target, store_valid, store_addr, store_data
   logic [1:0]  rsp_tuser;        // status

   exec_tracker tracker = new();

   // stretches where neither side idles
   logic        steady = 1'b0;
   int unsigned ready_hold = 0;
   int unsigned cycles = 0;

   cpu16_execute_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // mostly short gaps, now and then a long one
   function automatic int unsigned idle_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 50) return 0;
      if (pick < 88) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // one req transfer; valid stays high across back-to-back transfers
   task automatic send_instr(logic [OP_W-1:0] op, logic [REG_FIELD_W-1:0] ra,
                             logic [REG_FIELD_W-1:0] rb, logic [IMM_W-1:0] imm);
      int unsigned gap;
      gap = steady ? 0 : idle_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {6'b0, imm, rb, ra};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   function automatic logic [IMM_W-1:0] pick_imm();
      case ($urandom_range(0, 15))
         0:       return '0;
         1:       return '1;
         2:       return TOP_BIT;
         3:       return LOW_BIT;
         default: return IMM_W'($urandom);
      endcase
   endfunction

   // input side monitor: every accepted instruction updates the prediction
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready)
         tracker.note_instr(req_tuser, req_tdata[4:0], req_tdata[9:5], req_tdata[25:10]);
   end

   // result side monitor
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         tracker.check_result(rsp_tdata, rsp_tuser);
   end

   // receiver backpressure: random hold periods, ready in steady stretches once a hold runs out
   always @(posedge clock) begin
      if (ready_hold > 0) begin
         ready_hold <= ready_hold - 1;
      end else if (steady) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 99) < 65);
         ready_hold <= idle_gap();
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("tb_cpu16_execute_unit: FAIL");
         $finish;
      end
   end

   initial begin
      int unsigned pick;
      logic [OP_W-1:0] op;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: operand extremes, every opcode, flag corner cases
      send_instr(OP_LOADI, 5'd0,  5'd0,  16'hFFFF);
      send_instr(OP_LOADI, 5'd1,  5'd0,  16'h0001);
      send_instr(OP_LOADI, 5'd31, 5'd0,  16'h8000);
      send_instr(OP_ADD,   5'd0,  5'd1,  16'h0000);   // wraps to zero, carry out
      send_instr(OP_JUMPC, 5'd31, 5'd0,  16'h0000);   // taken on carry
      send_instr(OP_JUMPZ, 5'd31, 5'd0,  16'h0000);   // taken on zero
      send_instr(OP_ADDC,  5'd1,  5'd1,  16'h0000);   // carry in adds one
      send_instr(OP_SUB,   5'd0,  5'd1,  16'h0000);   // borrow
      send_instr(OP_SUBC,  5'd0,  5'd1,  16'h0000);   // borrow in
      send_instr(OP_COMP,  5'd31, 5'd31, 16'h0000);   // equal, no write
      send_instr(OP_JUMPC, 5'd1,  5'd0,  16'h0000);   // not taken
      send_instr(OP_JUMPZ, 5'd1,  5'd0,  16'h0000);
      send_instr(OP_DEC,   5'd2,  5'd0,  16'h0000);   // zero minus one borrows
      send_instr(OP_INC,   5'd2,  5'd0,  16'h0000);   // all ones plus one carries
      send_instr(OP_SHL,   5'd31, 5'd0,  16'h0000);   // top bit out, result zero
      send_instr(OP_SHLC,  5'd1,  5'd0,  16'h0000);   // carry shifted in
      send_instr(OP_SHRC,  5'd1,  5'd0,  16'h0000);
      send_instr(OP_SHR,   5'd1,  5'd0,  16'h0000);
      send_instr(OP_NOT,   5'd31, 5'd0,  16'h0000);
      send_instr(OP_AND,   5'd31, 5'd1,  16'h0000);
      send_instr(OP_OR,    5'd1,  5'd31, 16'h0000);
      send_instr(OP_XOR,   5'd1,  5'd1,  16'h0000);   // clears to zero
      send_instr(OP_MOVE,  5'd3,  5'd31, 16'h0000);
      send_instr(OP_STORE, 5'd3,  5'd1,  16'h0000);
      send_instr(OP_JUMP,  5'd3,  5'd0,  16'h0000);
      send_instr(OP_SLEEP, 5'd0,  5'd0,  16'h0000);   // no halted state kept
      send_instr(OP_FIRST_INVALID, 5'd0, 5'd0, 16'h0000);
      send_instr(OP_LAST_INVALID,  5'd31, 5'd31, 16'hFFFF);
      send_instr(OP_NOP,   5'd0,  5'd0,  16'h0000);

      // random: loadi often enough to keep register contents varied
      for (int n = 0; n < RANDOM_INSTRS; n++) begin
         if ($urandom_range(0, 49) == 0) steady <= ~steady;
         pick = $urandom_range(0, 99);
         if (pick < 15)
            op = OP_LOADI;
         else if (pick < 95)
            op = OP_W'($urandom_range(OP_NOP, OP_SHRC));
         else
            op = OP_W'($urandom_range(OP_FIRST_INVALID, OP_LAST_INVALID));
         send_instr(op, REG_FIELD_W'($urandom), REG_FIELD_W'($urandom), pick_imm());
      end
      req_tvalid <= 1'b0;
      steady     <= 1'b0;

      while (tracker.pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.mismatches == 0)
         $display("tb_cpu16_execute_unit: PASS");
      else
         $display("tb_cpu16_execute_unit: FAIL");
      $finish;
   end

endmodule

`default_nettype wire
